[rtl/bnsm_pkg.sv]
`default_nettype none

package bnsm_pkg;

   localparam int BAND_W   = 6;
   localparam int POWER_W  = 32;
   localparam int GAIN_W   = 19;
   localparam int FACTOR_W = 16;

   // Configuration register indexes (paddr[3:2]).
   localparam logic [1:0] CSR_RISE_FACTOR = 2'd0;
   localparam logic [1:0] CSR_FALL_FACTOR = 2'd1;
   localparam logic [1:0] CSR_PEAK_DECAY  = 2'd2;

   localparam logic [FACTOR_W-1:0] RISE_FACTOR_RESET = 16'd65470;
   localparam logic [FACTOR_W-1:0] FALL_FACTOR_RESET = 16'd32768;
   localparam logic [FACTOR_W-1:0] PEAK_DECAY_RESET  = 16'd55706;

   // Unity of the Q0.16 factors, and the fixed ratios in Q0.16.
   localparam logic [FACTOR_W:0] FACTOR_ONE      = 17'h10000;
   localparam logic [9:0]        LOW_BOUND_RATIO = 10'd655;
   localparam logic [13:0]       MASK_RATIO      = 14'd13107;
   localparam int                GAIN_MAX_INT    = 5;

   typedef struct packed {
      logic [BAND_W-1:0]  band;
      logic               first_frame;
      logic [POWER_W-1:0] medium_power;
      logic [POWER_W-1:0] short_power;
   } req_type;

   typedef struct packed {
      logic [BAND_W-1:0]  band_out;
      logic [POWER_W-1:0] masked_power;
      logic [GAIN_W-1:0]  gain;
      logic [POWER_W-1:0] weighted_power;
   } rsp_type;

   typedef struct packed {
      logic [FACTOR_W-1:0] rise_factor;
      logic [FACTOR_W-1:0] fall_factor;
      logic [FACTOR_W-1:0] peak_decay;
   } cfg_type;

   // One band's job after floor and masking, on its way to the gain divider.
   typedef struct packed {
      logic [BAND_W-1:0]  band;
      logic [POWER_W-1:0] medium_power;
      logic [POWER_W-1:0] short_power;
      logic [POWER_W-1:0] masked;
   } gain_job_type;

endpackage

`default_nettype wire

[rtl/band_noise_suppress_mask_gain_unit.sv]
`default_nettype none

// Per-band noise suppression with temporal masking and gain weighting. Each
// transaction on the request channel carries one band's medium-time and
// short-time power; each band keeps a noise floor and a decaying masking
// peak in an on-chip state memory, which is read, updated and written back
// for every transaction. The unit takes one request per clock cycle unless a
// state hazard or a stalled response holds it back. A request whose band
// maps to the same state entry as a request accepted in one of the three
// pipeline steps just before it is held back until that request has settled
// its new floor and peak, so a run of requests on a single band cannot be
// taken back to back; other requests are never delayed by it. Every request
// yields exactly one response, in order; the gain divider, which resolves
// one quotient bit per pipeline stage, makes up most of the pipeline. A
// stalled response channel does not stop the request channel until the
// pipeline has filled behind the waiting response. The state memory is not
// cleared by reset: the first request of each band must carry first_frame,
// which seeds that band's floor and peak. Band indexes at or above
// NUM_BANDS wrap onto the state memory modulo NUM_BANDS, while the response
// echoes the band as given. The three Q0.16 factors sit at byte addresses
// 0 (rise_factor), 4 (fall_factor) and 8 (peak_decay) of the APB port and
// must only be written while no transaction is in flight.
module band_noise_suppress_mask_gain_unit #(
   parameter int NUM_BANDS = 64,
   parameter int FRAC_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,

   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire bnsm_pkg::req_type req_payload,

   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output bnsm_pkg::rsp_type      rsp_payload,

   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [3:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic      [31:0]       prdata,
   output logic                   pready
);

   // Gain carries three integer bits, enough for the clamp at five.
   localparam int GW       = FRAC_BITS + 3;
   localparam int PROD_W   = bnsm_pkg::POWER_W + GW;
   localparam int GAIN_W   = bnsm_pkg::GAIN_W;
   localparam int SAT_W    = GW - FRAC_BITS;
   localparam logic [GW-1:0] GAIN_MAX = GW'(bnsm_pkg::GAIN_MAX_INT) << FRAC_BITS;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   bnsm_pkg::cfg_type cfg_ff, cfg_in;
   logic              cfg_write;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   // Writes to an address beyond the last register are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         unique case (paddr[3:2])
            bnsm_pkg::CSR_RISE_FACTOR: cfg_in.rise_factor = pwdata[15:0];
            bnsm_pkg::CSR_FALL_FACTOR: cfg_in.fall_factor = pwdata[15:0];
            bnsm_pkg::CSR_PEAK_DECAY:  cfg_in.peak_decay  = pwdata[15:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rise_factor <= bnsm_pkg::RISE_FACTOR_RESET;
         cfg_ff.fall_factor <= bnsm_pkg::FALL_FACTOR_RESET;
         cfg_ff.peak_decay  <= bnsm_pkg::PEAK_DECAY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         bnsm_pkg::CSR_RISE_FACTOR: prdata = 32'(cfg_ff.rise_factor);
         bnsm_pkg::CSR_FALL_FACTOR: prdata = 32'(cfg_ff.fall_factor);
         bnsm_pkg::CSR_PEAK_DECAY:  prdata = 32'(cfg_ff.peak_decay);
         default:                   prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Pipeline control
   // ---------------------------------------------------------------------
   // The whole pipeline moves as one. It only halts when its last stage
   // holds a result and the response register is still occupied, so empty
   // slots keep draining towards a waiting response.
   logic advance;
   logic hazard;
   logic mul_valid_ff;
   logic rsp_valid_ff, rsp_valid_in;

   assign advance   = !mul_valid_ff || !rsp_valid_ff || rsp_ready;
   assign req_ready = advance && !hazard;

   // ---------------------------------------------------------------------
   // Noise floor, masking peak and masked power
   // ---------------------------------------------------------------------
   logic                   job_valid;
   bnsm_pkg::gain_job_type job;

   bnsm_floor_peak #(
      .NUM_BANDS (NUM_BANDS)
   ) u_floor_peak (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid && req_ready),
      .in_item   (req_payload),
      .cfg       (cfg_ff),
      .hazard    (hazard),
      .out_valid (job_valid),
      .out_job   (job)
   );

   // ---------------------------------------------------------------------
   // Gain division
   // ---------------------------------------------------------------------
   logic                   div_valid;
   bnsm_pkg::gain_job_type div_job;
   logic                   div_overflow;
   logic [GW-1:0]          div_quotient;

   bnsm_gain_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_gain_div (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (job_valid),
      .in_job       (job),
      .out_valid    (div_valid),
      .out_job      (div_job),
      .out_overflow (div_overflow),
      .out_quotient (div_quotient)
   );

   // ---------------------------------------------------------------------
   // Gain clamp, weighting and saturation
   // ---------------------------------------------------------------------
   logic                               gain_valid_ff;
   logic [GW-1:0]                      gain_ff, gain_in;
   logic [bnsm_pkg::BAND_W-1:0]        gain_band_ff;
   logic [bnsm_pkg::POWER_W-1:0]       gain_short_ff;
   logic [bnsm_pkg::POWER_W-1:0]       gain_masked_ff;

   logic [PROD_W-1:0]                  mul_prod_ff;
   logic [GW-1:0]                      mul_gain_ff;
   logic [bnsm_pkg::BAND_W-1:0]        mul_band_ff;
   logic [bnsm_pkg::POWER_W-1:0]       mul_masked_ff;

   bnsm_pkg::rsp_type                  rsp_payload_ff, rsp_payload_in;

   assign gain_in = (div_overflow || (div_quotient > GAIN_MAX)) ? GAIN_MAX : div_quotient;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_valid_ff <= 1'b0;
         mul_valid_ff  <= 1'b0;
      end else if (advance) begin
         gain_valid_ff <= div_valid;
         mul_valid_ff  <= gain_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         gain_ff        <= gain_in;
         gain_band_ff   <= div_job.band;
         gain_short_ff  <= div_job.short_power;
         gain_masked_ff <= div_job.masked;

         mul_prod_ff    <= PROD_W'(gain_short_ff) * PROD_W'(gain_ff);
         mul_gain_ff    <= gain_ff;
         mul_band_ff    <= gain_band_ff;
         mul_masked_ff  <= gain_masked_ff;
      end
   end

   // The gain field keeps its low bits when the gain is wider than the field;
   // the weighting above always uses the full gain.
   always_comb begin
      rsp_payload_in.band_out     = mul_band_ff;
      rsp_payload_in.masked_power = mul_masked_ff;
      rsp_payload_in.gain         = GAIN_W'(mul_gain_ff);
      if (|mul_prod_ff[PROD_W-1 -: SAT_W]) begin
         rsp_payload_in.weighted_power = '1;
      end else begin
         rsp_payload_in.weighted_power = mul_prod_ff[FRAC_BITS +: bnsm_pkg::POWER_W];
      end
   end

   // ---------------------------------------------------------------------
   // Response register
   // ---------------------------------------------------------------------
   always_comb begin
      if (mul_valid_ff && advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_valid_ff && advance) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

[rtl/bnsm_ram.sv]
`default_nettype none

module bnsm_ram #(
   parameter int  WIDTH  = 64,
   parameter int  DEPTH  = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              write_en,
   input  wire logic [ADDR_W-1:0] write_addr,
   input  wire logic [WIDTH-1:0]  write_data,
   input  wire logic              read_en,
   input  wire logic [ADDR_W-1:0] read_addr,
   output logic      [WIDTH-1:0]  read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // A read and a write of the same entry in one cycle return the old data.
   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      if (read_en) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

[rtl/bnsm_floor_peak.sv]
`default_nettype none

module bnsm_floor_peak #(
   parameter int  NUM_BANDS = 64,
   localparam int IDX_W     = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic                   in_valid,
   input  wire bnsm_pkg::req_type      in_item,
   input  wire bnsm_pkg::cfg_type      cfg,
   output logic                        hazard,
   output logic                        out_valid,
   output bnsm_pkg::gain_job_type      out_job
);

   localparam int BAND_COUNT = 1 << bnsm_pkg::BAND_W;

   logic [IDX_W-1:0] idx_lut [BAND_COUNT];
   logic [IDX_W-1:0] in_idx;

   // Stage 1: memory data aligned with the item.
   logic                   v1_ff;
   bnsm_pkg::req_type      it1_ff;
   logic [IDX_W-1:0]       idx1_ff;
   logic [63:0]            ram_q;
   logic [31:0]            fwd_fl, fwd_pk, fl_old;
   logic [15:0]            keep_sel;

   // Stage 2: operands of the blends.
   logic                   v2_ff;
   bnsm_pkg::req_type      it2_ff;
   logic [IDX_W-1:0]       idx2_ff;
   logic [31:0]            fl_old2_ff, pk_old2_ff;
   logic [15:0]            keep2_ff;
   logic [16:0]            keep_inv;

   // Stage 3: products.
   logic                   v3_ff;
   bnsm_pkg::req_type      it3_ff;
   logic [IDX_W-1:0]       idx3_ff;
   logic [47:0]            keep_prod3_ff, decay_prod3_ff;
   logic [48:0]            new_prod3_ff;
   logic [41:0]            low_prod3_ff;
   logic [49:0]            blend_sum;

   // Stage 4: new floor, lower bound and decayed peak.
   logic                   v4_ff;
   bnsm_pkg::req_type      it4_ff;
   logic [IDX_W-1:0]       idx4_ff;
   logic [31:0]            fl4_ff, dpk4_ff;
   logic [25:0]            low4_ff;
   logic [31:0]            diff4, supp4, pk4;

   // Stage 5: final floor and peak, written back from here.
   logic                   v5_ff;
   bnsm_pkg::req_type      it5_ff;
   logic [IDX_W-1:0]       idx5_ff;
   logic [31:0]            fl5_ff, pk5_ff, supp5_ff;

   // Stage 6: masking threshold product.
   logic                   v6_ff;
   bnsm_pkg::req_type      it6_ff;
   logic [IDX_W-1:0]       idx6_ff;
   logic [31:0]            fl6_ff, pk6_ff, supp6_ff;
   logic [45:0]            thr_prod6_ff;
   logic [31:0]            thr6, masked6;

   // Stage 7: output.
   logic                   v7_ff;
   bnsm_pkg::gain_job_type job7_ff;

   for (genvar b = 0; b < BAND_COUNT; b++) begin : g_idx
      assign idx_lut[b] = IDX_W'(b % NUM_BANDS);
   end

   assign in_idx = idx_lut[in_item.band];

   // Items in stages 1 to 3 have not yet settled their new state.
   assign hazard = (v1_ff && (idx1_ff == in_idx)) ||
                   (v2_ff && (idx2_ff == in_idx)) ||
                   (v3_ff && (idx3_ff == in_idx));

   bnsm_ram #(
      .WIDTH (64),
      .DEPTH (NUM_BANDS)
   ) u_state_ram (
      .clock      (clock),
      .write_en   (v5_ff && advance),
      .write_addr (idx5_ff),
      .write_data ({pk5_ff, fl5_ff}),
      .read_en    (advance),
      .read_addr  (in_idx),
      .read_data  (ram_q)
   );

   // Stage 5 has not written yet; stage 6 wrote in the cycle of the read.
   always_comb begin
      if (v5_ff && (idx5_ff == idx1_ff)) begin
         fwd_fl = fl5_ff;
         fwd_pk = pk5_ff;
      end else if (v6_ff && (idx6_ff == idx1_ff)) begin
         fwd_fl = fl6_ff;
         fwd_pk = pk6_ff;
      end else begin
         fwd_fl = ram_q[31:0];
         fwd_pk = ram_q[63:32];
      end
      fl_old   = it1_ff.first_frame ? it1_ff.medium_power : fwd_fl;
      keep_sel = (it1_ff.medium_power >= fl_old) ? cfg.rise_factor : cfg.fall_factor;
   end

   assign keep_inv  = bnsm_pkg::FACTOR_ONE - {1'b0, keep2_ff};
   assign blend_sum = 50'(keep_prod3_ff) + 50'(new_prod3_ff);

   always_comb begin
      diff4 = (it4_ff.medium_power > fl4_ff) ? (it4_ff.medium_power - fl4_ff) : '0;
      supp4 = (diff4 < 32'(low4_ff)) ? 32'(low4_ff) : diff4;
      if (it4_ff.first_frame) begin
         pk4 = supp4;
      end else begin
         pk4 = (dpk4_ff < supp4) ? supp4 : dpk4_ff;
      end
   end

   assign thr6    = 32'(thr_prod6_ff[45:16]);
   assign masked6 = (supp6_ff >= thr6) ? supp6_ff : thr6;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         it1_ff  <= in_item;
         idx1_ff <= in_idx;

         it2_ff     <= it1_ff;
         idx2_ff    <= idx1_ff;
         fl_old2_ff <= fl_old;
         pk_old2_ff <= fwd_pk;
         keep2_ff   <= keep_sel;

         it3_ff         <= it2_ff;
         idx3_ff        <= idx2_ff;
         keep_prod3_ff  <= 48'(keep2_ff) * 48'(fl_old2_ff);
         new_prod3_ff   <= 49'(keep_inv) * 49'(it2_ff.medium_power);
         low_prod3_ff   <= 42'(it2_ff.medium_power) * 42'(bnsm_pkg::LOW_BOUND_RATIO);
         decay_prod3_ff <= 48'(cfg.peak_decay) * 48'(pk_old2_ff);

         it4_ff  <= it3_ff;
         idx4_ff <= idx3_ff;
         fl4_ff  <= blend_sum[47:16];
         low4_ff <= low_prod3_ff[41:16];
         dpk4_ff <= decay_prod3_ff[47:16];

         it5_ff   <= it4_ff;
         idx5_ff  <= idx4_ff;
         fl5_ff   <= fl4_ff;
         pk5_ff   <= pk4;
         supp5_ff <= supp4;

         it6_ff       <= it5_ff;
         idx6_ff      <= idx5_ff;
         fl6_ff       <= fl5_ff;
         pk6_ff       <= pk5_ff;
         supp6_ff     <= supp5_ff;
         thr_prod6_ff <= 46'(pk5_ff) * 46'(bnsm_pkg::MASK_RATIO);

         job7_ff.band         <= it6_ff.band;
         job7_ff.medium_power <= it6_ff.medium_power;
         job7_ff.short_power  <= it6_ff.short_power;
         job7_ff.masked       <= masked6;
      end
   end

   assign out_valid = v7_ff;
   assign out_job   = job7_ff;

endmodule

`default_nettype wire

[rtl/bnsm_gain_div.sv]
`default_nettype none

module bnsm_gain_div #(
   parameter int  FRAC_BITS = 16,
   localparam int GW        = FRAC_BITS + 3
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic                   in_valid,
   input  wire bnsm_pkg::gain_job_type in_job,
   output logic                        out_valid,
   output bnsm_pkg::gain_job_type      out_job,
   output logic                        out_overflow,
   output logic [GW-1:0]               out_quotient
);

   // Restoring division of (masked << FRAC_BITS) by (medium_power + 1), one
   // quotient bit per stage. A quotient of eight or more is flagged up front,
   // so the remaining quotient always fits in GW bits.
   logic                   valid_ff [GW+1];
   bnsm_pkg::gain_job_type job_ff   [GW+1];
   logic                   ovf_ff   [GW+1];
   logic [GW-1:0]          quo_ff   [GW+1];
   logic [32:0]            div_ff   [GW];
   logic [32:0]            rem_ff   [GW];

   logic [32:0] divisor_in;
   logic        ovf_in;

   assign divisor_in = 33'(in_job.medium_power) + 33'd1;
   assign ovf_in     = 36'(in_job.masked) >= {divisor_in, 3'b000};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         job_ff[0] <= in_job;
         div_ff[0] <= divisor_in;
         ovf_ff[0] <= ovf_in;
         rem_ff[0] <= 33'(in_job.masked[31:3]);
         quo_ff[0] <= '0;
      end
   end

   for (genvar k = 0; k < GW; k++) begin : g_step
      localparam int BIT_POS = GW - 1 - k;

      logic        dbit;
      logic [33:0] trial;
      logic [33:0] trial_diff;
      logic        take;

      if (BIT_POS >= FRAC_BITS) begin : g_data_bit
         assign dbit = job_ff[k].masked[BIT_POS-FRAC_BITS];
      end else begin : g_zero_bit
         assign dbit = 1'b0;
      end

      assign trial      = {rem_ff[k], dbit};
      assign take       = trial >= {1'b0, div_ff[k]};
      assign trial_diff = trial - {1'b0, div_ff[k]};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            job_ff[k+1] <= job_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
            quo_ff[k+1] <= {quo_ff[k][GW-2:0], take};
         end
      end

      if (k + 1 < GW) begin : g_carry
         logic [32:0] rem_in;

         assign rem_in = take ? trial_diff[32:0] : trial[32:0];

         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[k+1] <= rem_in;
               div_ff[k+1] <= div_ff[k];
            end
         end
      end
   end

   assign out_valid    = valid_ff[GW];
   assign out_job      = job_ff[GW];
   assign out_overflow = ovf_ff[GW];
   assign out_quotient = quo_ff[GW];

endmodule

`default_nettype wire

[tb/band_noise_suppress_mask_gain_unit_test.sv]
module band_noise_suppress_mask_gain_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   // The block is built at its default size. With six band bits and 64 bands,
   // every band maps onto a state entry of its own.
   localparam int NUM_BANDS_TB = 64;
   localparam int FRAC_BITS_TB = 16;

   typedef logic [bnsm_pkg::BAND_W-1:0]   band_type;
   typedef logic [bnsm_pkg::POWER_W-1:0]  power_type;
   typedef logic [bnsm_pkg::FACTOR_W-1:0] factor_type;

   // The register map has four word slots. Only the first three hold a
   // register, so a write to the last one must leave everything unchanged.
   localparam logic [1:0] CSR_UNMAPPED = 2'd3;

   // Fixed-point constants used by the predictor.
   localparam logic [63:0] FACTOR_UNITY = 64'd65536;
   localparam logic [63:0] GAIN_CEILING = 64'(bnsm_pkg::GAIN_MAX_INT) << FRAC_BITS_TB;
   localparam logic [63:0] POWER_FULL   = 64'h0000_0000_FFFF_FFFF;

   // Allowance for the pipeline latency. The drain after the last response
   // allows a little more.
   localparam int PIPE_LATENCY = FRAC_BITS_TB + 13;
   localparam int PHASE_SETTLE = 8;
   localparam int CYCLE_LIMIT  = 400_000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_ready;
   bnsm_pkg::req_type req_payload = '0;

   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   bnsm_pkg::rsp_type rsp_payload;

   logic        psel    = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite  = 1'b0;
   logic [3:0]  paddr   = '0;
   logic [31:0] pwdata  = '0;
   logic [31:0] prdata;
   logic        pready;

   band_noise_suppress_mask_gain_unit #(
      .NUM_BANDS(NUM_BANDS_TB),
      .FRAC_BITS(FRAC_BITS_TB)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   always #5 clock = ~clock;

   // Shadow copy of the configuration, as the block should hold it.
   factor_type rise_keep;
   factor_type fall_keep;
   factor_type decay_keep;

   // Shadow copy of the per-band state. A band counts as seeded once a
   // transaction carrying first_frame has been accepted for it; before that
   // its floor and peak are undefined in the block, so the stimulus never
   // reads them.
   power_type floor_track [NUM_BANDS_TB];
   power_type peak_track  [NUM_BANDS_TB];
   bit        band_seeded [NUM_BANDS_TB];

   // A loose loudness level per band. Most random powers wander around it so
   // that the floor is tracked both upwards and downwards, rather than being
   // thrown about by unrelated values.
   power_type band_level  [NUM_BANDS_TB];
   band_type  last_band;

   // Responses predicted for accepted requests, oldest first.
   bnsm_pkg::rsp_type pending_results [$];

   int unsigned error_count    = 0;
   int unsigned sent_count     = 0;
   int unsigned checked_count  = 0;
   int unsigned setting_count  = 0;
   int unsigned cycle_count    = 0;

   // Idle control for both sides. A maximum of zero gives a stretch in which
   // that side never idles. The hold-off, when set, makes the response side
   // refuse everything for that many cycles.
   int unsigned send_gap_max   = 10;
   int unsigned recv_stall_max = 10;
   int unsigned hold_off_cycles = 0;

   // Works out the response for one accepted request and updates the shadow
   // floor and peak of its band.
   function automatic bnsm_pkg::rsp_type predict_band_update(bnsm_pkg::req_type sample);
      logic [63:0] power;
      logic [63:0] short_pw;
      logic [63:0] floor_v;
      logic [63:0] keep;
      logic [63:0] suppressed;
      logic [63:0] lower_bound;
      logic [63:0] peak_v;
      logic [63:0] threshold;
      logic [63:0] masked;
      logic [63:0] gain_full;
      logic [63:0] weighted;
      int unsigned slot;
      bnsm_pkg::rsp_type result;
      slot     = sample.band % NUM_BANDS_TB;
      power    = 64'(sample.medium_power);
      short_pw = 64'(sample.short_power);

      // Asymmetric leaky floor; a first frame starts it from the power itself.
      floor_v = sample.first_frame ? power : 64'(floor_track[slot]);
      keep    = (power >= floor_v) ? 64'(rise_keep) : 64'(fall_keep);
      floor_v = (keep * floor_v + (FACTOR_UNITY - keep) * power) >> 16;

      // Subtract the floor, but never drop below one percent of the power.
      suppressed  = (power > floor_v) ? (power - floor_v) : 64'd0;
      lower_bound = (power * 64'(bnsm_pkg::LOW_BOUND_RATIO)) >> 16;
      if (suppressed < lower_bound) suppressed = lower_bound;

      // Decaying peak, and masking at a fifth of it.
      peak_v = sample.first_frame ? suppressed : 64'(peak_track[slot]);
      peak_v = (64'(decay_keep) * peak_v) >> 16;
      if (peak_v < suppressed) peak_v = suppressed;
      threshold = (peak_v * 64'(bnsm_pkg::MASK_RATIO)) >> 16;
      masked    = (suppressed >= threshold) ? suppressed : threshold;

      gain_full = (masked << FRAC_BITS_TB) / (power + 64'd1);
      if (gain_full > GAIN_CEILING) gain_full = GAIN_CEILING;
      weighted = (short_pw * gain_full) >> FRAC_BITS_TB;
      if (weighted > POWER_FULL) weighted = POWER_FULL;

      floor_track[slot] = floor_v[bnsm_pkg::POWER_W-1:0];
      peak_track[slot]  = peak_v[bnsm_pkg::POWER_W-1:0];
      band_seeded[slot] = 1'b1;

      result.band_out       = sample.band;
      result.masked_power   = masked[bnsm_pkg::POWER_W-1:0];
      result.gain           = gain_full[bnsm_pkg::GAIN_W-1:0];
      result.weighted_power = weighted[bnsm_pkg::POWER_W-1:0];
      return result;
   endfunction

   function automatic bnsm_pkg::req_type build_sample(band_type band, logic first,
                                                      power_type medium_pw,
                                                      power_type short_pw);
      bnsm_pkg::req_type sample;
      sample.band         = band;
      sample.first_frame  = first;
      sample.medium_power = medium_pw;
      sample.short_power  = short_pw;
      return sample;
   endfunction

   // Medium power for a random transaction: mostly values around the band's
   // level, with extremes and unrelated values mixed in as noise.
   function automatic power_type pick_medium_power(band_type band);
      power_type                  level;
      logic [bnsm_pkg::POWER_W:0] raised;
      if ($urandom_range(0, 15) == 0)
         band_level[band] = $urandom >> $urandom_range(0, 16);
      level = band_level[band];
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3: return $urandom;
         4: return $urandom_range(0, 32'hFFFF);
         5, 6: begin
            raised = {1'b0, level} + (level >> $urandom_range(1, 6));
            return raised[bnsm_pkg::POWER_W] ? '1 : raised[bnsm_pkg::POWER_W-1:0];
         end
         7: return level - (level >> $urandom_range(1, 6));
         default: return level >> $urandom_range(0, 8);
      endcase
   endfunction

   function automatic bnsm_pkg::req_type random_band_sample();
      band_type    band;
      power_type   short_pw;
      int unsigned pick;
      // Favour a handful of bands, and repeats of the last one, so that
      // back-to-back transactions on one band happen often.
      pick = $urandom_range(0, 9);
      if (pick < 4) band = band_type'($urandom_range(0, 3));
      else if (pick < 5) band = last_band;
      else band = band_type'($urandom_range(0, NUM_BANDS_TB - 1));
      last_band = band;
      case ($urandom_range(0, 7))
         0: short_pw = '0;
         1: short_pw = '1;
         default: short_pw = $urandom;
      endcase
      return build_sample(band, $urandom_range(0, 19) == 0,
                          pick_medium_power(band), short_pw);
   endfunction

   // Offers one transaction on the request channel and waits for it to be
   // taken. It is entered and left at a rising edge; valid stays high on
   // return, so a following call with no gap keeps the channel busy.
   task automatic offer_band_sample(bnsm_pkg::req_type sample);
      int unsigned gap;
      // An unseeded band would read undefined state, so its first
      // transaction always seeds it.
      if (!band_seeded[sample.band % NUM_BANDS_TB]) sample.first_frame = 1'b1;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= sample;
      do @(posedge clock); while (!req_ready);
      pending_results.insert(pending_results.size(), predict_band_update(sample));
      sent_count++;
   endtask

   // Drops the request channel and waits for every predicted response.
   task automatic settle_pipeline(int unsigned extra_cycles);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (extra_cycles) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] index, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      case (index)
         bnsm_pkg::CSR_RISE_FACTOR: rise_keep  = value[bnsm_pkg::FACTOR_W-1:0];
         bnsm_pkg::CSR_FALL_FACTOR: fall_keep  = value[bnsm_pkg::FACTOR_W-1:0];
         bnsm_pkg::CSR_PEAK_DECAY:  decay_keep = value[bnsm_pkg::FACTOR_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic csr_read_check(logic [1:0] index, factor_type expected);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {index, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[bnsm_pkg::FACTOR_W-1:0] !== expected) begin
         $error("register %0d: expected %0d, actual %0d", index, expected,
                prdata[bnsm_pkg::FACTOR_W-1:0]);
         error_count++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(logic [31:0] rise, logic [31:0] fall, logic [31:0] decay);
      csr_write(bnsm_pkg::CSR_RISE_FACTOR, rise);
      csr_write(bnsm_pkg::CSR_FALL_FACTOR, fall);
      csr_write(bnsm_pkg::CSR_PEAK_DECAY, decay);
      csr_read_check(bnsm_pkg::CSR_RISE_FACTOR, rise_keep);
      csr_read_check(bnsm_pkg::CSR_FALL_FACTOR, fall_keep);
      csr_read_check(bnsm_pkg::CSR_PEAK_DECAY, decay_keep);
      setting_count++;
   endtask

   task automatic check_response(bnsm_pkg::rsp_type got);
      bnsm_pkg::rsp_type want;
      if (pending_results.size() == 0) begin
         $error("unexpected response for band %0d with nothing outstanding", got.band_out);
         error_count++;
      end else begin
         want = pending_results.pop_front();
         if (got.band_out !== want.band_out) begin
            $error("band_out: expected %0d, actual %0d", want.band_out, got.band_out);
            error_count++;
         end
         if (got.masked_power !== want.masked_power) begin
            $error("masked_power: expected %0h, actual %0h",
                   want.masked_power, got.masked_power);
            error_count++;
         end
         if (got.gain !== want.gain) begin
            $error("gain: expected %0h, actual %0h", want.gain, got.gain);
            error_count++;
         end
         if (got.weighted_power !== want.weighted_power) begin
            $error("weighted_power: expected %0h, actual %0h",
                   want.weighted_power, got.weighted_power);
            error_count++;
         end
      end
      checked_count++;
   endtask

   // The factors must come out of reset at their documented values.
   task automatic test_reset_values();
      csr_read_check(bnsm_pkg::CSR_RISE_FACTOR, bnsm_pkg::RISE_FACTOR_RESET);
      csr_read_check(bnsm_pkg::CSR_FALL_FACTOR, bnsm_pkg::FALL_FACTOR_RESET);
      csr_read_check(bnsm_pkg::CSR_PEAK_DECAY, bnsm_pkg::PEAK_DECAY_RESET);
   endtask

   // Directed transactions at the reset settings: zero and full-scale powers,
   // the lowest and highest band, a quiet frame after a loud one so that the
   // masking threshold drives the gain into its ceiling and the weighted
   // power into saturation, and a floor pushed both up and down.
   task automatic test_directed_extremes();
      offer_band_sample(build_sample(6'd0,  1'b1, '0, '0));
      offer_band_sample(build_sample(6'd63, 1'b1, '1, '1));
      offer_band_sample(build_sample(6'd63, 1'b0, '1, '1));
      offer_band_sample(build_sample(6'd0,  1'b0, '0, '1));
      offer_band_sample(build_sample(6'd0,  1'b0, 32'h0000_0001, '1));
      offer_band_sample(build_sample(6'd1,  1'b1, 32'h03E8_0000, '1));
      offer_band_sample(build_sample(6'd1,  1'b0, 32'h0000_0001, '1));
      offer_band_sample(build_sample(6'd1,  1'b0, '0, '1));
      offer_band_sample(build_sample(6'd1,  1'b0, 32'h0000_0010, 32'h0001_0000));
      offer_band_sample(build_sample(6'd2,  1'b1, 32'h0001_0000, 32'h0001_0000));
      offer_band_sample(build_sample(6'd2,  1'b0, 32'h0064_0000, 32'h0001_0000));
      offer_band_sample(build_sample(6'd2,  1'b0, 32'h0064_0000, 32'hAAAA_AAAA));
      offer_band_sample(build_sample(6'd2,  1'b0, '0, 32'h5555_5555));
      offer_band_sample(build_sample(6'd2,  1'b1, 32'h8000_0000, '1));
      offer_band_sample(build_sample(6'd63, 1'b0, 32'h0000_0100, '1));
      offer_band_sample(build_sample(6'd63, 1'b0, 32'hFFFF_0000, 32'h0000_FFFF));
      offer_band_sample(build_sample(6'd32, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000));
      offer_band_sample(build_sample(6'd32, 1'b0, 32'h7FFF_FFFE, 32'h8000_0000));
      offer_band_sample(build_sample(6'd32, 1'b0, 32'h0000_0002, 32'h0000_0001));
      offer_band_sample(build_sample(6'd0,  1'b1, '1, '0));
      settle_pipeline(PHASE_SETTLE);
   endtask

   // Runs a burst of random transactions, switching the idle pattern of both
   // sides every fifty transactions so that some stretches run flat out.
   task automatic run_random_burst(int unsigned count);
      for (int unsigned n = 0; n < count; n++) begin
         if (n % 50 == 0) begin
            send_gap_max   = $urandom_range(0, 2) == 0 ? 0 : 10;
            recv_stall_max = $urandom_range(0, 2) == 0 ? 0 : 10;
         end
         offer_band_sample(random_band_sample());
      end
   endtask

   // Walks the factors through their extremes and a random setting, with
   // random traffic under each. The unmapped slot is written with noise in
   // between and must leave the factors untouched.
   task automatic test_register_settings();
      apply_setting(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      run_random_burst(60);
      settle_pipeline(PHASE_SETTLE);
      apply_setting(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF);
      run_random_burst(60);
      settle_pipeline(PHASE_SETTLE);
      apply_setting(32'hFFFF_0000, 32'h0000_FFFF, 32'h0000_0000);
      run_random_burst(60);
      settle_pipeline(PHASE_SETTLE);
      apply_setting(32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_FFFF);
      csr_write(CSR_UNMAPPED, $urandom);
      csr_read_check(bnsm_pkg::CSR_RISE_FACTOR, rise_keep);
      csr_read_check(bnsm_pkg::CSR_FALL_FACTOR, fall_keep);
      csr_read_check(bnsm_pkg::CSR_PEAK_DECAY, decay_keep);
      run_random_burst(60);
      settle_pipeline(PHASE_SETTLE);
      apply_setting($urandom, $urandom, $urandom);
      run_random_burst(60);
      settle_pipeline(PHASE_SETTLE);
      apply_setting(32'(bnsm_pkg::RISE_FACTOR_RESET), 32'(bnsm_pkg::FALL_FACTOR_RESET),
                    32'(bnsm_pkg::PEAK_DECAY_RESET));
   endtask

   // The response side refuses everything for a long while as the request
   // side keeps offering transactions back to back, so the pipeline fills
   // and the request channel has to stall.
   task automatic test_back_pressure();
      send_gap_max    = 0;
      hold_off_cycles = 300;
      for (int unsigned n = 0; n < 120; n++) offer_band_sample(random_band_sample());
      settle_pipeline(PHASE_SETTLE);
   endtask

   task automatic test_random_traffic();
      run_random_burst(620);
      send_gap_max   = 10;
      recv_stall_max = 10;
      settle_pipeline(PHASE_SETTLE);
   endtask

   // Response side: before each transaction it draws a stall, then holds ready
   // high until one is taken. A pending hold-off is served first.
   initial begin : response_sink
      int unsigned stall;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_off_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
         end
         stall = $urandom_range(0, recv_stall_max);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         check_response(rsp_payload);
      end
   end

   // A hung handshake must not stall the run for ever.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin : test_sequence
      rise_keep  = bnsm_pkg::RISE_FACTOR_RESET;
      fall_keep  = bnsm_pkg::FALL_FACTOR_RESET;
      decay_keep = bnsm_pkg::PEAK_DECAY_RESET;
      last_band  = '0;
      for (int b = 0; b < NUM_BANDS_TB; b++) begin
         floor_track[b] = '0;
         peak_track[b]  = '0;
         band_seeded[b] = 1'b0;
         band_level[b]  = $urandom >> $urandom_range(0, 16);
      end

      // Reset is held once and released on an edge.
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_directed_extremes();
      test_register_settings();
      test_back_pressure();
      test_random_traffic();

      // Every response is in; give the pipeline its latency to show anything
      // stray before the verdict.
      settle_pipeline(PIPE_LATENCY + 16);

      $display("Covered %0d request transactions and %0d checked responses.",
               sent_count, checked_count);
      $display("Factors were taken through %0d settings, including both extremes.",
               setting_count);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
